// ===== src/idt_pkg.sv =====
// Shared types, constants and decode for the instruction dependency tracker.
`default_nettype none

package idt_pkg;

  localparam int NameCountDef = 64;
  localparam int IdWidthDef   = 10;
  localparam int NameW        = 6;
  localparam int IdFieldW     = 10;
  localparam int KindW        = 3;

  typedef enum logic [KindW-1:0] {
    KindAdd   = 3'd0,
    KindSub   = 3'd1,
    KindLw    = 3'd2,
    KindSw    = 3'd3,
    KindBeq   = 3'd4,
    KindBnq   = 3'd5,
    KindOther = 3'd6
  } kind_e;

  typedef struct packed {
    logic             use_a;
    logic             use_b;
    logic [NameW-1:0] name_a;
    logic [NameW-1:0] name_b;
    logic             produces;
    logic [NameW-1:0] dest;
  } dec_t;

  // Operand roles per instruction kind.
  function automatic dec_t decode(logic [KindW-1:0] kind, logic [NameW-1:0] op1,
                                  logic [NameW-1:0] op2, logic [NameW-1:0] op3);
    dec_t d;
    d = '0;
    case (kind)
      KindAdd, KindSub: begin
        d.use_a = 1'b1;  d.name_a = op2;
        d.use_b = 1'b1;  d.name_b = op3;
        d.produces = 1'b1;  d.dest = op1;
      end
      KindLw: begin
        d.use_a = 1'b1;  d.name_a = op2;
        d.produces = 1'b1;  d.dest = op1;
      end
      KindSw: begin
        d.use_a = 1'b1;  d.name_a = op1;
        d.produces = 1'b1;  d.dest = op2;
      end
      KindBeq, KindBnq: begin
        d.use_a = 1'b1;  d.name_a = op1;
        d.use_b = 1'b1;  d.name_b = op2;
      end
      default: begin
        d = '0;
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/idt_writer_mem.sv =====
// Producer id memory: one write port, two registered read ports.
`default_nettype none

module idt_writer_mem
  import idt_pkg::*;
#(
  parameter int Depth = NameCountDef,
  parameter int Width = IdWidthDef,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_a_q;
  logic [Width-1:0] rd_b_q;

  // Read-before-write on a same-address collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

`default_nettype wire

// ===== src/instruction_dependency_tracker_core.sv =====
// Top level of the read-after-write instruction dependency tracker.
`default_nettype none

// Usage:
//   Input channel: an item (one decoded instruction) is taken at a rising edge
//   with start_i high and busy_o low. busy_o never rises, so one item can be
//   taken every cycle. start_req_i on an item clears the producer table
//   before that item's lookup.
//   Result channel: valid_o pulses for one cycle, in the cycle after the
//   item was taken, with the lookup for source a and source b. Results are
//   not held: the receiver must take them in that cycle.
//   Throughput is one item per cycle; results come from the registered
//   read of the producer id memory. Its write happens in the accept cycle, so
//   the next item's read already sees it and needs no forwarding.
//   Valid bits per name live in flip-flops and clear at reset; the id memory
//   needs no clear and its data is only used for names with a set valid bit.
//   Tokens at or beyond NAME_COUNT are never recorded and never found.
//   Reset (rst_ni low, asynchronous) drops any pending result and clears
//   the table.

module instruction_dependency_tracker_core
  import idt_pkg::*;
#(
  parameter int NAME_COUNT = NameCountDef,
  parameter int ID_WIDTH   = IdWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [KindW-1:0]    kind_i,
  input  wire logic                start_req_i,
  input  wire logic [IdFieldW-1:0] instr_id_i,
  input  wire logic [NameW-1:0]    op1_name_i,
  input  wire logic [NameW-1:0]    op2_name_i,
  input  wire logic [NameW-1:0]    op3_name_i,
  output logic                     valid_o,
  output logic                     src_a_found_o,
  output logic [NameW-1:0]         src_a_name_o,
  output logic [IdFieldW-1:0]      src_a_writer_o,
  output logic                     src_b_found_o,
  output logic [NameW-1:0]         src_b_name_o,
  output logic [IdFieldW-1:0]      src_b_writer_o
);

  localparam int IdxW = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;

  logic accept;
  dec_t dec;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign dec    = decode(kind_i, op1_name_i, op2_name_i, op3_name_i);

  // Token to table index, with range check against NAME_COUNT.
  logic [IdxW+NameW-1:0] ext_a, ext_b, ext_d;
  logic [IdxW-1:0]       idx_a, idx_b, idx_d;
  logic                  rng_a, rng_b, rng_d;

  assign ext_a = {{IdxW{1'b0}}, dec.name_a};
  assign ext_b = {{IdxW{1'b0}}, dec.name_b};
  assign ext_d = {{IdxW{1'b0}}, dec.dest};
  assign idx_a = ext_a[IdxW-1:0];
  assign idx_b = ext_b[IdxW-1:0];
  assign idx_d = ext_d[IdxW-1:0];
  assign rng_a = (32'(dec.name_a) < NAME_COUNT);
  assign rng_b = (32'(dec.name_b) < NAME_COUNT);
  assign rng_d = (32'(dec.dest) < NAME_COUNT);

  // Valid bits: cleared by a start item, then the produced name is set.
  logic [NAME_COUNT-1:0] wvalid_q, wvalid_d;
  logic                  rec;

  assign rec = accept && dec.produces && rng_d;

  always_comb begin
    wvalid_d = wvalid_q;
    if (accept && start_req_i) begin
      wvalid_d = '0;
    end
    if (rec) begin
      wvalid_d[idx_d] = 1'b1;
    end
  end

  // Lookup sees the table after a start clear but before this item's record.
  logic hit_a, hit_b;
  assign hit_a = dec.use_a && rng_a && !start_req_i && wvalid_q[idx_a];
  assign hit_b = dec.use_b && rng_b && !start_req_i && wvalid_q[idx_b];

  // Producer ids.
  logic [ID_WIDTH+IdFieldW-1:0] id_ext;
  logic [ID_WIDTH-1:0]          wr_a, wr_b;

  assign id_ext = {{ID_WIDTH{1'b0}}, instr_id_i};

  idt_writer_mem #(
    .Depth(NAME_COUNT),
    .Width(ID_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (rec),
    .waddr_i   (idx_d),
    .wdata_i   (id_ext[ID_WIDTH-1:0]),
    .raddr_a_i (idx_a),
    .raddr_b_i (idx_b),
    .rdata_a_o (wr_a),
    .rdata_b_o (wr_b)
  );

  // Result stage, aligned with the memory read data.
  logic             valid_q;
  logic             found_a_q, found_b_q;
  logic [NameW-1:0] name_a_q, name_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      wvalid_q <= '0;
    end else begin
      valid_q  <= accept;
      wvalid_q <= wvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_a_q <= hit_a;
      found_b_q <= hit_b;
      name_a_q  <= dec.use_a ? dec.name_a : '0;
      name_b_q  <= dec.use_b ? dec.name_b : '0;
    end
  end

  logic [IdFieldW+ID_WIDTH-1:0] wr_a_ext, wr_b_ext;
  assign wr_a_ext = {{IdFieldW{1'b0}}, wr_a};
  assign wr_b_ext = {{IdFieldW{1'b0}}, wr_b};

  assign valid_o        = valid_q;
  assign src_a_found_o  = found_a_q;
  assign src_a_name_o   = name_a_q;
  assign src_a_writer_o = found_a_q ? wr_a_ext[IdFieldW-1:0] : '0;
  assign src_b_found_o  = found_b_q;
  assign src_b_name_o   = name_b_q;
  assign src_b_writer_o = found_b_q ? wr_b_ext[IdFieldW-1:0] : '0;

endmodule

`default_nettype wire
